FILE: rtl/core/pcapdf_pkg.sv
// ----------------------------------------------------------------------------
// pcapdf_pkg - shared definitions for the PCAP stream deframer
// Result codes, header constants, byte-order helpers and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package pcapdf_pkg;

    localparam int unsigned GLOBAL_LEN = 24;
    localparam int unsigned RECORD_LEN = 16;

    localparam logic [31:0] MAX_PKT_RESET = 32'd262144;

    // Magic words as read little-endian
    localparam logic [31:0] MAGIC_US      = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_US_SWAP = 32'hD4C3B2A1;
    localparam logic [31:0] MAGIC_NS      = 32'hA1B23C4D;
    localparam logic [31:0] MAGIC_NS_SWAP = 32'h4D3CB2A1;

    localparam logic [15:0] FMT_REV_HI = 16'd2;
    localparam logic [15:0] FMT_REV_LO = 16'd4;

    typedef enum logic [1:0] {
        KIND_GLOBAL  = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_TRUNC_GLOBAL = 4'd1,
        ST_BAD_MAGIC    = 4'd2,
        ST_BAD_VERSION  = 4'd3,
        ST_BAD_SNAPLEN  = 4'd4,
        ST_TRUNC_RECORD = 4'd5,
        ST_TRUNC_DATA   = 4'd6,
        ST_OVER_SNAPLEN = 4'd7,
        ST_OVER_MAX     = 4'd8,
        ST_CLEAN_END    = 4'd9
    } status_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] ts_seconds;
        logic [31:0] ts_fraction;
        logic [31:0] captured_length;
        logic [31:0] original_length;
        logic [7:0]  payload_byte;
        logic        packet_last;
        logic        nanosecond_mode;
        logic [31:0] link_type;
        logic [31:0] snap_length;
    } result_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcap_stream_deframer.sv
// ----------------------------------------------------------------------------
// pcap_stream_deframer - classic PCAP byte stream parser
// Parses the global header and record headers and forwards payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one capture byte per transaction, or
//   an end-of-stream marker (is_end high, in_byte ignored).
//   Output channel (out_valid / out_stall): zero or one result per input
//   transaction: global header accepted, record header, payload byte, status.
//   Config channel (cfg_valid / cfg_ready): writes max_packet_size; ready is
//   always high. Write only while the block is idle.
//   Timing: the input register loads at the accepting edge and the result
//   register loads from it once the result register is free. Throughput: one
//   byte per cycle while the output is not stalled, set by the single parse
//   step between those two registers.
//   Reset: parser returns to the global header phase, max_packet_size goes
//   to 262144, both registers empty.
//   Stall: while the result register is full and stalled, the input register,
//   once full, holds and in_stall rises; nothing is dropped. Any parse error halts the
//   block until reset: inputs are still taken but give no results.
// ----------------------------------------------------------------------------
`default_nettype none

module pcap_stream_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_end,
    // config channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [3:0]       status,
    output logic [31:0]      ts_seconds,
    output logic [31:0]      ts_fraction,
    output logic [31:0]      captured_length,
    output logic [31:0]      original_length,
    output logic [7:0]       payload_byte,
    output logic             packet_last,
    output logic             nanosecond_mode,
    output logic [31:0]      link_type,
    output logic [31:0]      snap_length
);

    typedef enum logic [2:0] {
        PH_GLOBAL,
        PH_RECORD,
        PH_PAYLOAD,
        PH_DONE,
        PH_HALT
    } phase_t;

    localparam logic [4:0] IDX_MAGIC   = 5'd3;
    localparam logic [4:0] IDX_VERSION = 5'd7;
    localparam logic [4:0] IDX_SNAPLEN = 5'd19;
    localparam logic [4:0] IDX_G_LAST  = 5'(pcapdf_pkg::GLOBAL_LEN - 1);
    localparam logic [4:0] IDX_TS_SEC  = 5'd3;
    localparam logic [4:0] IDX_TS_FRAC = 5'd7;
    localparam logic [4:0] IDX_CAPLEN  = 5'd11;
    localparam logic [4:0] IDX_R_LAST  = 5'(pcapdf_pkg::RECORD_LEN - 1);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        is_end_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [4:0]          byte_index_reg, byte_index_next;
    logic [31:0]         word_shift_reg, word_shift_next;
    logic                byte_swapped_reg, byte_swapped_next;
    logic                nano_reg, nano_next;
    logic [31:0]         snap_reg, snap_next;
    logic [31:0]         link_reg, link_next;
    logic [31:0]         rec_sec_reg, rec_sec_next;
    logic [31:0]         rec_frac_reg, rec_frac_next;
    logic [31:0]         rec_cap_reg, rec_cap_next;
    logic [31:0]         remaining_reg, remaining_next;
    pcapdf_pkg::status_t pending_reg, pending_next;
    logic [31:0]         max_pkt_reg, max_pkt_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    pcapdf_pkg::result_t out_reg, out_next;

    logic                out_free;
    logic                proc_fire;
    logic                in_accept;
    logic                res_valid;
    pcapdf_pkg::result_t res;
    logic [31:0]         ws_new;
    logic [31:0]         word_val;
    logic [31:0]         magic_word;
    logic [15:0]         ver_major;
    logic [15:0]         ver_minor;
    logic [31:0]         remaining_dec;

    // Handshake: the input register drains when the result register can take
    // a new value this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Assemble the current 32-bit field; bytes arrive least significant first
    // in native order.
    assign ws_new        = {word_shift_reg[23:0], in_byte_reg};
    assign word_val      = byte_swapped_reg ? ws_new : pcapdf_pkg::swap32(ws_new);
    assign magic_word    = pcapdf_pkg::swap32(ws_new);
    assign ver_major     = byte_swapped_reg ? ws_new[31:16]
                                            : pcapdf_pkg::swap16(ws_new[31:16]);
    assign ver_minor     = byte_swapped_reg ? ws_new[15:0]
                                            : pcapdf_pkg::swap16(ws_new[15:0]);
    assign remaining_dec = remaining_reg - 32'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        word_shift_next   = word_shift_reg;
        byte_swapped_next = byte_swapped_reg;
        nano_next         = nano_reg;
        snap_next         = snap_reg;
        link_next         = link_reg;
        rec_sec_next      = rec_sec_reg;
        rec_frac_next     = rec_frac_reg;
        rec_cap_next      = rec_cap_reg;
        remaining_next    = remaining_reg;
        pending_next      = pending_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (proc_fire)
        begin
            case (phase_reg)
                PH_GLOBAL:
                begin
                    if (is_end_reg)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = pcapdf_pkg::KIND_STATUS;
                        res.status = pcapdf_pkg::ST_TRUNC_GLOBAL;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        word_shift_next = ws_new;
                        byte_index_next = byte_index_reg + 5'd1;
                        case (byte_index_reg)
                            IDX_MAGIC:
                            begin
                                case (magic_word)
                                    pcapdf_pkg::MAGIC_US:
                                    begin
                                        byte_swapped_next = 1'b0;
                                        nano_next         = 1'b0;
                                    end
                                    pcapdf_pkg::MAGIC_US_SWAP:
                                    begin
                                        byte_swapped_next = 1'b1;
                                        nano_next         = 1'b0;
                                    end
                                    pcapdf_pkg::MAGIC_NS:
                                    begin
                                        byte_swapped_next = 1'b0;
                                        nano_next         = 1'b1;
                                    end
                                    pcapdf_pkg::MAGIC_NS_SWAP:
                                    begin
                                        byte_swapped_next = 1'b1;
                                        nano_next         = 1'b1;
                                    end
                                    default:
                                        pending_next = pcapdf_pkg::ST_BAD_MAGIC;
                                endcase
                            end
                            IDX_VERSION:
                            begin
                                if (pending_reg == pcapdf_pkg::ST_OK &&
                                    (ver_major != pcapdf_pkg::FMT_REV_HI ||
                                     ver_minor != pcapdf_pkg::FMT_REV_LO))
                                    pending_next = pcapdf_pkg::ST_BAD_VERSION;
                            end
                            IDX_SNAPLEN:
                            begin
                                snap_next = word_val;
                                if (pending_reg == pcapdf_pkg::ST_OK && word_val == '0)
                                    pending_next = pcapdf_pkg::ST_BAD_SNAPLEN;
                            end
                            IDX_G_LAST:
                            begin
                                link_next       = word_val;
                                byte_index_next = '0;
                                res_valid       = 1'b1;
                                if (pending_reg != pcapdf_pkg::ST_OK)
                                begin
                                    res.kind   = pcapdf_pkg::KIND_STATUS;
                                    res.status = pending_reg;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    res.kind            = pcapdf_pkg::KIND_GLOBAL;
                                    res.nanosecond_mode = nano_reg;
                                    res.link_type       = word_val;
                                    res.snap_length     = snap_reg;
                                    phase_next          = PH_RECORD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                PH_RECORD:
                begin
                    if (is_end_reg)
                    begin
                        res_valid = 1'b1;
                        res.kind  = pcapdf_pkg::KIND_STATUS;
                        if (byte_index_reg == '0)
                        begin
                            res.status = pcapdf_pkg::ST_CLEAN_END;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            res.status = pcapdf_pkg::ST_TRUNC_RECORD;
                            phase_next = PH_HALT;
                        end
                    end
                    else
                    begin
                        word_shift_next = ws_new;
                        byte_index_next = byte_index_reg + 5'd1;
                        case (byte_index_reg)
                            IDX_TS_SEC:  rec_sec_next  = word_val;
                            IDX_TS_FRAC: rec_frac_next = word_val;
                            IDX_CAPLEN:  rec_cap_next  = word_val;
                            IDX_R_LAST:
                            begin
                                byte_index_next = '0;
                                res_valid       = 1'b1;
                                // snaplen check takes priority over the limit
                                if (rec_cap_reg > snap_reg)
                                begin
                                    res.kind   = pcapdf_pkg::KIND_STATUS;
                                    res.status = pcapdf_pkg::ST_OVER_SNAPLEN;
                                    phase_next = PH_HALT;
                                end
                                else if (rec_cap_reg > max_pkt_reg)
                                begin
                                    res.kind   = pcapdf_pkg::KIND_STATUS;
                                    res.status = pcapdf_pkg::ST_OVER_MAX;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    res.kind            = pcapdf_pkg::KIND_RECORD;
                                    res.ts_seconds      = rec_sec_reg;
                                    res.ts_fraction     = rec_frac_reg;
                                    res.captured_length = rec_cap_reg;
                                    res.original_length = word_val;
                                    res.packet_last     = (rec_cap_reg == '0);
                                    res.nanosecond_mode = nano_reg;
                                    res.link_type       = link_reg;
                                    res.snap_length     = snap_reg;
                                    remaining_next      = rec_cap_reg;
                                    phase_next = (rec_cap_reg == '0) ? PH_RECORD
                                                                     : PH_PAYLOAD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    if (is_end_reg)
                    begin
                        res.kind   = pcapdf_pkg::KIND_STATUS;
                        res.status = pcapdf_pkg::ST_TRUNC_DATA;
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        remaining_next      = remaining_dec;
                        res.kind            = pcapdf_pkg::KIND_PAYLOAD;
                        res.payload_byte    = in_byte_reg;
                        res.packet_last     = (remaining_dec == '0);
                        res.nanosecond_mode = nano_reg;
                        res.link_type       = link_reg;
                        res.snap_length     = snap_reg;
                        if (remaining_dec == '0)
                            phase_next = PH_RECORD;
                    end
                end

                PH_DONE:
                begin
                    // ignore bytes; answer each further end again
                    if (is_end_reg)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = pcapdf_pkg::KIND_STATUS;
                        res.status = pcapdf_pkg::ST_CLEAN_END;
                    end
                end

                default:
                begin
                    // halted: drop everything
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = proc_fire && res_valid;
            if (proc_fire && res_valid)
                out_next = res;
        end

        max_pkt_next = cfg_valid ? cfg_data : max_pkt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            in_byte_reg      <= '0;
            is_end_reg       <= 1'b0;
            phase_reg        <= PH_GLOBAL;
            byte_index_reg   <= '0;
            word_shift_reg   <= '0;
            byte_swapped_reg <= 1'b0;
            nano_reg         <= 1'b0;
            snap_reg         <= '0;
            link_reg         <= '0;
            rec_sec_reg      <= '0;
            rec_frac_reg     <= '0;
            rec_cap_reg      <= '0;
            remaining_reg    <= '0;
            pending_reg      <= pcapdf_pkg::ST_OK;
            max_pkt_reg      <= pcapdf_pkg::MAX_PKT_RESET;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (in_accept)
            begin
                in_byte_reg <= in_byte;
                is_end_reg  <= is_end;
            end
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            word_shift_reg   <= word_shift_next;
            byte_swapped_reg <= byte_swapped_next;
            nano_reg         <= nano_next;
            snap_reg         <= snap_next;
            link_reg         <= link_next;
            rec_sec_reg      <= rec_sec_next;
            rec_frac_reg     <= rec_frac_next;
            rec_cap_reg      <= rec_cap_next;
            remaining_reg    <= remaining_next;
            pending_reg      <= pending_next;
            max_pkt_reg      <= max_pkt_next;
            out_valid_reg    <= out_valid_next;
            out_reg          <= out_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign status          = out_reg.status;
    assign ts_seconds      = out_reg.ts_seconds;
    assign ts_fraction     = out_reg.ts_fraction;
    assign captured_length = out_reg.captured_length;
    assign original_length = out_reg.original_length;
    assign payload_byte    = out_reg.payload_byte;
    assign packet_last     = out_reg.packet_last;
    assign nanosecond_mode = out_reg.nanosecond_mode;
    assign link_type       = out_reg.link_type;
    assign snap_length     = out_reg.snap_length;

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("parser left halt without reset");

    // Header byte counters stay inside their header
    a_global_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GLOBAL |-> byte_index_reg < 5'(pcapdf_pkg::GLOBAL_LEN))
        else $error("global header index out of range");

    a_record_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RECORD |-> byte_index_reg < 5'(pcapdf_pkg::RECORD_LEN))
        else $error("record header index out of range");

    // Payload phase always has bytes left to pass
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != '0)
        else $error("payload phase with no bytes remaining");

    // Input only stalls behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

FILE: bench/tb_pcap_stream_deframer.sv
// ----------------------------------------------------------------------------
// tb_pcap_stream_deframer - self-checking bench for the PCAP stream deframer
// Feeds one capture stream (global header, many records, one way of ending)
// with random idle and stall gaps, predicts every result and compares them.
// ----------------------------------------------------------------------------

import pcapdf_pkg::*;

typedef enum logic [2:0] {
    STAGE_GLOBAL,
    STAGE_RECORD,
    STAGE_PAYLOAD,
    STAGE_ENDED,
    STAGE_HALTED
} parse_stage_t;

typedef enum int {
    FINISH_CLEAN,
    FINISH_TRUNC_RECORD,
    FINISH_TRUNC_DATA,
    FINISH_OVER_SNAPLEN,
    FINISH_OVER_MAX
} stream_finish_t;

class capture_tracker;
    parse_stage_t stage;
    int unsigned  pos;
    logic [31:0]  shifter;
    bit           swapped;
    bit           nano;
    logic [31:0]  snap;
    logic [31:0]  link;
    logic [31:0]  secs;
    logic [31:0]  frac;
    logic [31:0]  caplen;
    logic [31:0]  left;
    logic [31:0]  max_len;
    status_t      fault;
    result_t      pending_results[$];
    int unsigned  fails;

    function new();
        stage   = STAGE_GLOBAL;
        pos     = 0;
        shifter = '0;
        swapped = 1'b0;
        nano    = 1'b0;
        snap    = '0;
        link    = '0;
        secs    = '0;
        frac    = '0;
        caplen  = '0;
        left    = '0;
        max_len = MAX_PKT_RESET;
        fault   = ST_OK;
        fails   = 0;
    endfunction

    function void set_max(logic [31:0] v);
        max_len = v;
    endfunction

    // last four bytes as a field in file byte order
    function logic [31:0] file_word();
        logic [31:0] le;
        le = {<<8{shifter}};
        return swapped ? shifter : le;
    endfunction

    function result_t framed(kind_t k);
        result_t r;
        r                 = '0;
        r.kind            = k;
        r.status          = ST_OK;
        r.nanosecond_mode = nano;
        r.link_type       = link;
        r.snap_length     = snap;
        return r;
    endfunction

    function void post_status(status_t s, parse_stage_t next_stage);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = s;
        pending_results.push_back(r);
        stage = next_stage;
    endfunction

    function void global_byte();
        int unsigned idx;
        logic [31:0] le;
        logic [15:0] major;
        logic [15:0] minor;
        idx = pos;
        pos = pos + 1;
        if (idx == 3)
        begin
            le = {<<8{shifter}};
            case (le)
                MAGIC_US:
                begin
                    swapped = 1'b0;
                    nano    = 1'b0;
                end
                MAGIC_US_SWAP:
                begin
                    swapped = 1'b1;
                    nano    = 1'b0;
                end
                MAGIC_NS:
                begin
                    swapped = 1'b0;
                    nano    = 1'b1;
                end
                MAGIC_NS_SWAP:
                begin
                    swapped = 1'b1;
                    nano    = 1'b1;
                end
                default:       fault = ST_BAD_MAGIC;
            endcase
        end
        else if (idx == 7)
        begin
            if (swapped)
            begin
                major = shifter[31:16];
                minor = shifter[15:0];
            end
            else
            begin
                major = {shifter[23:16], shifter[31:24]};
                minor = {shifter[7:0], shifter[15:8]};
            end
            if (fault == ST_OK && (major != FMT_REV_HI || minor != FMT_REV_LO))
                fault = ST_BAD_VERSION;
        end
        else if (idx == 19)
        begin
            snap = file_word();
            if (fault == ST_OK && snap == 0)
                fault = ST_BAD_SNAPLEN;
        end
        else if (idx == GLOBAL_LEN - 1)
        begin
            link = file_word();
            pos  = 0;
            if (fault != ST_OK)
                post_status(fault, STAGE_HALTED);
            else
            begin
                pending_results.push_back(framed(KIND_GLOBAL));
                stage = STAGE_RECORD;
            end
        end
    endfunction

    function void record_byte();
        int unsigned idx;
        result_t     r;
        idx = pos;
        pos = pos + 1;
        if (idx == 3)
            secs = file_word();
        else if (idx == 7)
            frac = file_word();
        else if (idx == 11)
            caplen = file_word();
        else if (idx == RECORD_LEN - 1)
        begin
            pos = 0;
            if (caplen > snap)
                post_status(ST_OVER_SNAPLEN, STAGE_HALTED);
            else if (caplen > max_len)
                post_status(ST_OVER_MAX, STAGE_HALTED);
            else
            begin
                r                 = framed(KIND_RECORD);
                r.ts_seconds      = secs;
                r.ts_fraction     = frac;
                r.captured_length = caplen;
                r.original_length = file_word();
                r.packet_last     = (caplen == 0);
                pending_results.push_back(r);
                left  = caplen;
                stage = (caplen == 0) ? STAGE_RECORD : STAGE_PAYLOAD;
            end
        end
    endfunction

    // note one accepted input transaction and queue what it should produce
    function void note_item(logic [7:0] b, logic e);
        result_t r;
        case (stage)
            STAGE_GLOBAL:
            begin
                if (e)
                    post_status(ST_TRUNC_GLOBAL, STAGE_HALTED);
                else
                begin
                    shifter = {shifter[23:0], b};
                    global_byte();
                end
            end
            STAGE_RECORD:
            begin
                if (e)
                begin
                    if (pos == 0)
                        post_status(ST_CLEAN_END, STAGE_ENDED);
                    else
                        post_status(ST_TRUNC_RECORD, STAGE_HALTED);
                end
                else
                begin
                    shifter = {shifter[23:0], b};
                    record_byte();
                end
            end
            STAGE_PAYLOAD:
            begin
                if (e)
                    post_status(ST_TRUNC_DATA, STAGE_HALTED);
                else
                begin
                    left           = left - 1;
                    r              = framed(KIND_PAYLOAD);
                    r.payload_byte = b;
                    r.packet_last  = (left == 0);
                    pending_results.push_back(r);
                    if (left == 0)
                        stage = STAGE_RECORD;
                end
            end
            STAGE_ENDED:
            begin
                if (e)
                    post_status(ST_CLEAN_END, STAGE_ENDED);
            end
            default: ;
        endcase
    endfunction

    function void diff_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, seen);
            fails++;
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing pending, expected none, actual kind %0d",
                     $time, got.kind);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        diff_field("kind", want.kind, got.kind);
        diff_field("status", want.status, got.status);
        diff_field("ts_seconds", want.ts_seconds, got.ts_seconds);
        diff_field("ts_fraction", want.ts_fraction, got.ts_fraction);
        diff_field("captured_length", want.captured_length, got.captured_length);
        diff_field("original_length", want.original_length, got.original_length);
        diff_field("payload_byte", want.payload_byte, got.payload_byte);
        diff_field("packet_last", want.packet_last, got.packet_last);
        diff_field("nanosecond_mode", want.nanosecond_mode, got.nanosecond_mode);
        diff_field("link_type", want.link_type, got.link_type);
        diff_field("snap_length", want.snap_length, got.snap_length);
    endfunction
endclass

module tb_pcap_stream_deframer;

    // cycles without any transaction on any channel before the run is abandoned
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PHASE_ITEMS   = 160;
    localparam int unsigned SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        is_end = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [31:0] ts_seconds;
    logic [31:0] ts_fraction;
    logic [31:0] captured_length;
    logic [31:0] original_length;
    logic [7:0]  payload_byte;
    logic        packet_last;
    logic        nanosecond_mode;
    logic [31:0] link_type;
    logic [31:0] snap_length;

    capture_tracker tracker = new();

    // stimulus state: byte order of the file being built and current limits
    bit          file_be;
    bit          in_quiet;
    logic [31:0] snap_now;
    logic [31:0] max_now = MAX_PKT_RESET;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned hold_left;
    bit          out_quiet;

    pcap_stream_deframer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .is_end          (is_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .status          (status),
        .ts_seconds      (ts_seconds),
        .ts_fraction     (ts_fraction),
        .captured_length (captured_length),
        .original_length (original_length),
        .payload_byte    (payload_byte),
        .packet_last     (packet_last),
        .nanosecond_mode (nanosecond_mode),
        .link_type       (link_type),
        .snap_length     (snap_length)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Captured length for a well-formed record, bounded by both limits.
    // Keep most packets short so the run stays quick.
    function automatic logic [31:0] pick_length(logic [31:0] lim);
        int unsigned r;
        logic [31:0] top;
        r = $urandom_range(0, 99);
        if (lim == 0 || r < 15)
            return 0;
        if (r < 90)
            top = (lim < 24) ? lim : 24;
        else
            top = (lim < 256) ? lim : 256;
        return $urandom_range(1, top);
    endfunction

    function automatic logic [31:0] length_limit();
        return (snap_now < max_now) ? snap_now : max_now;
    endfunction

    // Drive one input transaction and hold it until the block takes it.
    // The caller is always at a rising edge, so valid gets a single update
    // per time step: either dropped for a gap or kept high with new data.
    task automatic send_item(input logic [7:0] b, input logic e);
        int unsigned gap;
        gap = in_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_end   <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(b, e);
        items_sent++;
    endtask

    // One 32-bit header field in the byte order of the file.
    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            send_item(file_be ? w[31 - 8 * i -: 8] : w[8 * i +: 8], 1'b0);
    endtask

    task automatic send_half(input logic [15:0] h);
        send_item(file_be ? h[15:8] : h[7:0], 1'b0);
        send_item(file_be ? h[7:0] : h[15:8], 1'b0);
    endtask

    // Record header followed by data_bytes payload bytes; data_bytes below
    // cap gives a record cut short.
    task automatic send_record(input logic [31:0] sec, input logic [31:0] frac,
                               input logic [31:0] cap, input logic [31:0] orig,
                               input int unsigned data_bytes);
        in_quiet = ($urandom_range(0, 4) == 0);
        send_word(sec);
        send_word(frac);
        send_word(cap);
        send_word(orig);
        for (int unsigned i = 0; i < data_bytes; i++)
            send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Drop valid and hold off until every predicted result has arrived,
    // then let the pipeline drain of inputs that produce nothing.
    task automatic wait_idle(input int unsigned settle);
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_max(input logic [31:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_max(v);
        max_now = v;
        cfg_valid <= 1'b0;
    endtask

    // Random bytes and end markers after the stream is over: a halted block
    // must ignore all of them, an ended one answers each marker.
    task automatic send_noise(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted transaction, stall at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_side
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got                 = '0;
            got.kind            = kind_t'(kind);
            got.status          = status_t'(status);
            got.ts_seconds      = ts_seconds;
            got.ts_fraction     = ts_fraction;
            got.captured_length = captured_length;
            got.original_length = original_length;
            got.payload_byte    = payload_byte;
            got.packet_last     = packet_last;
            got.nanosecond_mode = nanosecond_mode;
            got.link_type       = link_type;
            got.snap_length     = snap_length;
            tracker.check_result(got);
        end
        // flip between stall-free stretches and random stalling now and then
        if ($urandom_range(0, 299) == 0)
            out_quiet <= ~out_quiet;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!out_quiet)
                hold_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any channel restarts the count.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stream_finish_t finish_kind;
        logic [31:0]    magic;
        logic [31:0]    settings [5];
        logic [31:0]    cap;
        logic [31:0]    lim;
        int unsigned    phase_end;
        int unsigned    sel;

        finish_kind = stream_finish_t'($urandom_range(0, 4));

        // pick one of the four magic words; the swapped ones give a
        // big-endian file
        sel = $urandom_range(0, 3);
        case (sel)
            0:       magic = MAGIC_US;
            1:       magic = MAGIC_US_SWAP;
            2:       magic = MAGIC_NS;
            default: magic = MAGIC_NS_SWAP;
        endcase
        file_be = (magic == MAGIC_US_SWAP) || (magic == MAGIC_NS_SWAP);

        // an all-ones snaplen leaves no room for the over-snaplen ending
        if (finish_kind == FINISH_OVER_SNAPLEN || $urandom_range(0, 2) != 0)
            snap_now = $urandom_range(300, 70000);
        else
            snap_now = 32'hFFFF_FFFF;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset value of the size limit:
        // global header, then a zero-length record with all-ones fields,
        //         then a short record with all-zero fields and one with random fields.
        in_quiet = 1'b0;
        for (int i = 0; i < 4; i++)
            send_item(magic[8 * i +: 8], 1'b0);
        send_half(FMT_REV_HI);
        send_half(FMT_REV_LO);
        send_word($urandom);            // thiszone, dropped
        send_word($urandom);            // sigfigs, dropped
        send_word(snap_now);
        send_word($urandom);            // link type
        send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 0);
        send_record(32'd0, 32'd0, 32'd1, 32'd0, 1);
        send_record($urandom, $urandom, 32'd3, $urandom, 3);

        // Random part in phases, each with its own size limit. The last
        // phase leaves the limit wide open for the stream ending.
        settings[0] = 32'd0;
        settings[1] = $urandom_range(1, 40);
        settings[2] = $urandom;
        settings[3] = MAX_PKT_RESET;
        settings[4] = 32'hFFFF_FFFF;
        for (int p = 0; p < 5; p++)
        begin
            wait_idle(SETTLE_CYCLES);
            write_max(settings[p]);
            lim = length_limit();
            // first record of a phase sits exactly on the limit when short
            if (lim <= 256)
                send_record($urandom, $urandom, lim, $urandom, lim);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                cap = pick_length(lim);
                send_record($urandom, $urandom, cap, $urandom, cap);
            end
        end

        // End the stream in the chosen way, then throw noise at it.
        wait_idle(SETTLE_CYCLES);
        in_quiet = 1'b0;
        case (finish_kind)
            FINISH_CLEAN:
            begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            FINISH_TRUNC_RECORD:
            begin
                repeat ($urandom_range(1, RECORD_LEN - 1))
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            FINISH_TRUNC_DATA:
            begin
                cap = $urandom_range(1, 30);
                send_record($urandom, $urandom, cap, $urandom, $urandom_range(0, cap - 1));
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            FINISH_OVER_SNAPLEN:
            begin
                cap = $urandom_range(snap_now + 1, 32'hFFFF_FFFF);
                send_record($urandom, $urandom, cap, $urandom, 0);
            end
            default:
            begin
                // limit below a length that snaplen would allow
                wait_idle(SETTLE_CYCLES);
                write_max($urandom_range(0, 200));
                cap = $urandom_range(max_now + 1, snap_now);
                send_record($urandom, $urandom, cap, $urandom, 0);
            end
        endcase
        send_noise(24);

        wait_idle(SETTLE_CYCLES + 8);
        if (tracker.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pcapdf_pkg.sv
rtl/core/pcap_stream_deframer.sv
bench/tb_pcap_stream_deframer.sv
